>>> rtl/semc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semc_pkg
// Shared constants for the Sobel edge magnitude block: parameter defaults, field
// widths, frame height limit, register indexes and register reset values.
// ----------------------------------------------------------------------------
package semc_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // Fixed field widths
  localparam int PIXEL_W     = 8;
  localparam int EDGE_W      = 16;
  localparam int EDGE_MAX    = 65535;
  localparam int DIM_W       = 11;
  localparam int CLIP_W      = 12;
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 2;

  // Frame height limit, row counter width
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = DIM_W;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_LEVEL   = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]  RESET_FRAME_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0]  RESET_FRAME_HEIGHT = 11'd480;
  localparam logic [CLIP_W-1:0] RESET_CLIP_LEVEL   = 12'd0;

endpackage

>>> rtl/semc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module semc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/semc_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semc_isqrt
// Bit-serial integer square root, rounded down. One root bit per cycle;
// done pulses with root valid.
// ----------------------------------------------------------------------------
module semc_isqrt #(
  parameter int ROOT_W = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done,
  output logic [ROOT_W-1:0]     root
);

  localparam int CNT_W = $clog2(ROOT_W);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [2*ROOT_W-1:0] rad;
  logic [ROOT_W-1:0]   rem;
  logic [ROOT_W+1:0]   rem_shift;
  logic [ROOT_W+1:0]   trial;
  logic [ROOT_W+1:0]   diff;
  logic                fits;

  // bring down the next two radicand bits, try 4*root+1
  assign rem_shift = {rem, rad[2*ROOT_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign fits      = (rem_shift >= trial);
  assign diff      = rem_shift - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // last root bit lands this cycle
      done <= busy && !start && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W - 1);
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad <= {rad[2*ROOT_W-3:0], 2'b00};
        if (fits) begin
          rem  <= diff[ROOT_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_shift[ROOT_W-1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/sobel_edge_magnitude_clip.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_clip
// 3x3 Sobel gradient magnitude over a raster pixel stream, with clip offset.
// ----------------------------------------------------------------------------
// Pixels arrive in row order, one per transaction on s_*. The two rows above
// the current one live in a single line RAM (one word per column holding both
// rows); a two-column window of registers supplies the rest of the 3x3
// neighborhood, with pixels outside the frame read as zero. For each pixel
// the block forms gx and gy, squares and sums them, takes an integer square
// root m and sends max(0, m + floor(m*clip/2^PIXEL_BITS) - clip), saturated to
// 16 bits, on m_*. The result for pixel (x,y) leaves when the item at (x+1,y+1)
// is taken, so after a frame the host sends one row plus one item of flush
// transactions (s_tuser high); the result for the last pixel of the frame
// carries m_tlast, and the next transaction starts a new frame. A flush
// transaction inside the frame is dropped; a pixel past the frame end counts
// as a zero flush. Timing: one item at a time. A dropped flush stays in
// ST_IDLE, an item without a result passes through ST_UPD, and one with a
// result on through ST_SQX, ST_SQY, ST_ROOT (serial square root, one root
// bit per cycle), ST_ADD and ST_FIN. s_tready is high whenever the block is
// between items, even while a result waits on m_*. The user writes frame
// size and clip registers over cfg_* while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_clip #(
  parameter int MAX_WIDTH  = semc_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = semc_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [semc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [semc_pkg::CFG_W-1:0]       cfg_data,
  // pixel stream in
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [semc_pkg::PIXEL_W-1:0]     s_tdata,   // [7:0] pixel
  input  logic                             s_tuser,   // [0] flush
  // edge stream out
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [semc_pkg::EDGE_W-1:0]      m_tdata,   // [15:0] edge_value
  output logic                             m_tlast    // frame_last
);

  localparam int P       = PIXEL_BITS;
  localparam int COL_W   = $clog2(MAX_WIDTH + 1);
  localparam int ADDR_W  = $clog2(MAX_WIDTH);
  localparam int CW      = (COL_W > semc_pkg::DIM_W) ? COL_W : semc_pkg::DIM_W;
  localparam int ROW_W   = semc_pkg::ROW_W;
  localparam int VIN_W   = (P < semc_pkg::PIXEL_W) ? P : semc_pkg::PIXEL_W;
  localparam int G_W     = P + 3;                 // signed gradient
  localparam int SQ_W    = 2 * G_W;               // gx^2 + gy^2
  localparam int R_W     = G_W;                   // root
  localparam int PROD_W  = R_W + semc_pkg::CLIP_W;
  localparam int VAL_W   = ((R_W > 15) ? R_W : 16) + 1;
  localparam int EDGE_W  = semc_pkg::EDGE_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_UPD, ST_SQX, ST_SQY, ST_ROOT, ST_ADD, ST_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [semc_pkg::DIM_W-1:0]  frame_width;
  logic [semc_pkg::DIM_W-1:0]  frame_height;
  logic [semc_pkg::CLIP_W-1:0] clip_level;

  // position and window
  logic [COL_W-1:0]        column_count;
  logic [ROW_W-1:0]        row_count;
  logic [2:0][P-1:0]       win_old;
  logic [2:0][P-1:0]       win_new;
  logic [P-1:0]            item_v;
  logic                    item_last;

  // datapath registers
  logic signed [G_W-1:0]   gx_r;
  logic signed [G_W-1:0]   gy_r;
  logic [SQ_W-1:0]         sq;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [R_W-1:0]          sqrt_root;
  logic [PROD_W-1:0]       prod;
  logic [VAL_W-1:0]        val;

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= semc_pkg::RESET_FRAME_WIDTH;
      frame_height <= semc_pkg::RESET_FRAME_HEIGHT;
      clip_level   <= semc_pkg::RESET_CLIP_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        semc_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[semc_pkg::DIM_W-1:0];
        semc_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[semc_pkg::DIM_W-1:0];
        semc_pkg::CFG_CLIP_LEVEL:   clip_level   <= cfg_data[semc_pkg::CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- effective frame size, clamped ----
  logic [CW-1:0]    fw_ext;
  logic [COL_W-1:0] w_lim;
  logic [ROW_W-1:0] h_lim;
  logic [ROW_W-1:0] h_p1;

  assign fw_ext = CW'(frame_width);

  always_comb begin
    if (fw_ext == '0) begin
      w_lim = COL_W'(1);
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      w_lim = COL_W'(MAX_WIDTH);
    end else begin
      w_lim = COL_W'(fw_ext);
    end
    if (frame_height == '0) begin
      h_lim = ROW_W'(1);
    end else if (frame_height > ROW_W'(semc_pkg::MAX_HEIGHT)) begin
      h_lim = ROW_W'(semc_pkg::MAX_HEIGHT);
    end else begin
      h_lim = frame_height;
    end
  end

  assign h_p1 = h_lim + 1'b1;

  // ---- stream position of the offered item ----
  // Stale rows past the flush rows restart the frame; a column at or past
  // the width wraps to the next row.
  logic [COL_W-1:0] pos_col;
  logic [ROW_W-1:0] pos_row;
  logic             pos_restart;
  logic             pos_drop;
  logic             s_accept;
  logic [P-1:0]     pix_in;

  always_comb begin
    pos_col     = column_count;
    pos_row     = row_count;
    pos_restart = 1'b0;
    if (row_count > h_p1) begin
      pos_col     = '0;
      pos_row     = '0;
      pos_restart = 1'b1;
    end
    if (pos_col >= w_lim) begin
      pos_col = '0;
      pos_row = pos_row + 1'b1;
      if (pos_row > h_p1) begin
        pos_row     = '0;
        pos_restart = 1'b1;
      end
    end
  end

  // flush inside the frame: position moves (wrap/restart) but nothing else
  assign pos_drop = (pos_row < h_lim) && s_tuser;
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign pix_in   = P'(s_tdata[VIN_W-1:0]);

  // ---- line RAM: word = {two rows up, one row up} ----
  logic              ram_we;
  logic [2*P-1:0]    ram_wdata;
  logic [2*P-1:0]    ram_rdata;
  logic [P-1:0]      rd_one;
  logic [P-1:0]      rd_two;

  assign rd_one    = ram_rdata[P-1:0];
  assign rd_two    = ram_rdata[2*P-1:P];
  assign ram_we    = (state == ST_UPD);
  assign ram_wdata = {rd_one, item_v};

  // read issued while idle, data lands in ST_UPD
  semc_ram #(
    .WIDTH (2 * P),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (column_count[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (pos_col[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // ---- window column and gradients (ST_UPD) ----
  logic [2:0][P-1:0]     col3;
  logic [2:0][P-1:0]     right;
  logic                  col_zero;
  logic                  upd_emit;
  logic                  upd_last;
  logic [G_W-1:0]        sum_r;
  logic [G_W-1:0]        sum_l;
  logic [G_W-1:0]        sum_t;
  logic [G_W-1:0]        sum_b;
  logic signed [G_W-1:0] gx;
  logic signed [G_W-1:0] gy;

  always_comb begin
    col3[0]  = (row_count >= ROW_W'(2)) ? rd_two : '0;
    col3[1]  = (row_count >= ROW_W'(1)) ? rd_one : '0;
    col3[2]  = item_v;
    col_zero = (column_count == '0);
    // at column zero the result belongs to the previous row's last pixel,
    // whose right neighbor lies outside the frame
    right    = col_zero ? '0 : col3;
    if (col_zero) begin
      upd_emit = (row_count >= ROW_W'(2)) && (row_count <= h_p1);
      upd_last = (row_count == h_p1);
    end else begin
      upd_emit = (row_count >= ROW_W'(1)) && (row_count <= h_lim);
      upd_last = 1'b0;
    end
    sum_r = G_W'(right[0]) + G_W'({right[1], 1'b0}) + G_W'(right[2]);
    sum_l = G_W'(win_old[0]) + G_W'({win_old[1], 1'b0}) + G_W'(win_old[2]);
    sum_t = G_W'(win_old[0]) + G_W'({win_new[0], 1'b0}) + G_W'(right[0]);
    sum_b = G_W'(win_old[2]) + G_W'({win_new[2], 1'b0}) + G_W'(right[2]);
    gx    = $signed(sum_r - sum_l);
    gy    = $signed(sum_t - sum_b);
  end

  // ---- shared squarer ----
  logic signed [G_W-1:0]  g_sel;
  logic signed [SQ_W-1:0] g_sq;

  assign g_sel = (state == ST_SQX) ? gx_r : gy_r;
  assign g_sq  = g_sel * g_sel;

  semc_isqrt #(
    .ROOT_W (R_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // ---- clip and saturate (ST_FIN) ----
  logic [VAL_W-1:0]  clip_ext;
  logic [VAL_W-1:0]  val_diff;
  logic [EDGE_W-1:0] edge_value;

  assign clip_ext = VAL_W'(clip_level);
  assign val_diff = val - clip_ext;

  always_comb begin
    if (val <= clip_ext) begin
      edge_value = '0;
    end else if (val_diff > VAL_W'(semc_pkg::EDGE_MAX)) begin
      edge_value = EDGE_W'(semc_pkg::EDGE_MAX);
    end else begin
      edge_value = val_diff[EDGE_W-1:0];
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
      win_old      <= '0;
      win_new      <= '0;
      sqrt_start   <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      // root unit kicks off as the squared sum is formed
      sqrt_start <= (state == ST_SQY);
      // ST_FIN either holds or reloads the output register itself
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            column_count <= pos_col;
            row_count    <= pos_row;
            if (pos_restart) begin
              win_old <= '0;
              win_new <= '0;
            end
            if (!pos_drop) begin
              item_v <= (pos_row >= h_lim) ? '0 : pix_in;
              state  <= ST_UPD;
            end
          end
        end
        ST_UPD: begin
          gx_r      <= gx;
          gy_r      <= gy;
          item_last <= upd_last;
          if (upd_emit && upd_last) begin
            // frame done: next transaction starts a new frame
            column_count <= '0;
            row_count    <= '0;
            win_old      <= '0;
            win_new      <= '0;
          end else begin
            column_count <= column_count + 1'b1;
            win_old      <= col_zero ? '0 : win_new;
            win_new      <= col3;
          end
          state <= upd_emit ? ST_SQX : ST_IDLE;
        end
        ST_SQX: begin
          sq    <= unsigned'(g_sq);
          state <= ST_SQY;
        end
        ST_SQY: begin
          sq    <= sq + unsigned'(g_sq);
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (sqrt_done) begin
            prod  <= sqrt_root * clip_level;
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          val   <= VAL_W'(sqrt_root) + VAL_W'(prod[PROD_W-1:P]);
          state <= ST_FIN;
        end
        ST_FIN: begin
          // output register holds one result; wait until it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= edge_value;
            m_tlast  <= item_last;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // ---- assertions ----
  // the root unit only finishes while the sequencer waits on it
  a_root_done_in_root: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> (state == ST_ROOT))
    else $error("square root finished outside of root wait");

  // the last result of a frame rewinds the position
  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && upd_emit && upd_last) |=>
      (column_count == '0 && row_count == '0))
    else $error("frame end did not reset the stream position");

  // a pending result is never overwritten by the next one
  a_fin_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && m_tvalid && !m_tready) |=> (state == ST_FIN && m_tvalid))
    else $error("result loaded over a pending transaction");

endmodule
